>>> src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ESG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define ESG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/esg_pkg.sv
// package for the entropy sum and gradient block: field widths, constants, state type
// no dependencies
package esg_pkg;

    localparam int PROB_W     = 33;
    localparam int GRAD_W     = 32;
    localparam int TOTAL_W    = 48;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 88;
    localparam int ACC_WIDTH_DEF = 48;

    localparam int FRAC_BITS  = 24;
    localparam int NORM_STEPS = 6;
    localparam int NLN_W      = 30;

    localparam logic [31:0]       LN2_Q32      = 32'hB172_17F8;
    localparam logic [NLN_W-1:0]  NEG_LN_ZERO  = 30'd964689920;
    localparam logic [31:0]       UPSTREAM_RST = 32'h0001_0000;

    localparam logic REQ_ACC      = 1'b0;
    localparam logic REQ_GRAD     = 1'b1;
    localparam logic KIND_ENTROPY = 1'b0;
    localparam logic KIND_GRAD    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQ,
        ST_LNMUL,
        ST_LNRND,
        ST_TMUL,
        ST_TACC,
        ST_TOUT,
        ST_GMUL,
        ST_GRND,
        ST_GOUT
    } esg_state_t;

endpackage

>>> src/entropy_sum_and_gradient_top.sv
// entropy sum and gradient block, natural log, fixed point, one shared multiplier
// depends on esg_pkg
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tdata: prob, grad_in; tuser: req_type; tlast: last
//  m_        out  m_tvalid/m_tready    tdata: entropy_total, grad_out, saturated;
//                                      tuser: result_kind
//  cfg_      in   cfg_valid/cfg_ready  cfg_data: upstream_gradient
//
// nonzero prob: normalise, log squaring rounds, ln multiply and round, then term
// multiply, accumulate and, with last, total output, or gradient multiply, round
// and output; zero prob skips the log, whose 24 squaring rounds share the one multiplier
// reset clears the sum, the overflow flag and sets upstream_gradient to 1.0
// a waiting result stalls only the end of the next item, not its acceptance
module entropy_sum_and_gradient_top
    import esg_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // prob[32:0], grad_in[64:33], zero pad
    input  logic                 s_tuser,   // req_type
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // entropy_total[47:0], grad_out[79:48],
                                            // saturated[80], zero pad
    output logic                 m_tuser,   // result_kind
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    localparam int TOT_EXT_W = (ACC_WIDTH > TOTAL_W) ? ACC_WIDTH : TOTAL_W;

    esg_state_t state_reg, state_next;

    logic                 req_reg, req_next;
    logic                 last_reg, last_next;
    logic [31:0]          p_reg, p_next;
    logic [PROB_W-1:0]    norm_reg, norm_next;
    logic [GRAD_W-1:0]    grad_reg, grad_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [5:0]           lz_reg, lz_next;
    logic [30:0]          x_reg, x_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [NLN_W-1:0]     neg_ln_reg, neg_ln_next;
    logic signed [41:0]   delta_reg, delta_next;
    logic signed [65:0]   prod_reg;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic                 ovf_reg, ovf_next;
    logic [31:0]          upstream_reg, upstream_next;

    logic                 mvalid_reg, mvalid_next;
    logic                 okind_reg, okind_next;
    logic [TOTAL_W-1:0]   ototal_reg, ototal_next;
    logic [GRAD_W-1:0]    ograd_reg, ograd_next;
    logic                 osat_reg, osat_next;

    logic                 accept;
    logic                 out_free;
    logic [PROB_W-1:0]    prob_clamp;
    logic                 prob_zero;
    logic [5:0]           shamt;
    logic                 top_zero;
    logic [PROB_W-1:0]    p_step;
    logic signed [32:0]   mul_a, mul_b;
    logic signed [65:0]   mul_p;
    logic [31:0]          sq_t;
    logic [29:0]          nlog2;
    logic [63:0]          rnd_sum;
    logic [24:0]          term;
    logic [ACC_WIDTH:0]   acc_add;
    logic signed [32:0]   grad_scale;
    logic signed [65:0]   biased;
    logic signed [42:0]   r_full;
    logic [TOT_EXT_W-1:0] acc_ext;
    logic                 tot_clip;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = {7'b0, osat_reg, ograd_reg, ototal_reg};

    // probabilities above one are clamped to one
    assign prob_clamp = (s_tdata[PROB_W-1] && (s_tdata[PROB_W-2:0] != '0))
                        ? {1'b1, {(PROB_W-1){1'b0}}} : s_tdata[PROB_W-1:0];
    assign prob_zero  = (prob_clamp == '0);

    // leading zero search, halving shift per step
    assign shamt    = 6'd32 >> cnt_reg[2:0];
    assign top_zero = ((norm_reg >> (6'd33 - shamt)) == '0);
    assign p_step   = top_zero ? (norm_reg << shamt) : norm_reg;

    assign mul_p      = mul_a * mul_b;
    assign sq_t       = mul_p[61:30];
    assign nlog2      = {lz_reg, {FRAC_BITS{1'b0}}} - {6'b0, frac_reg};
    assign rnd_sum    = prod_reg[63:0] + 64'h0000_0000_8000_0000;
    assign term       = rnd_sum[56:32];
    assign acc_add    = {1'b0, acc_reg} + {{(ACC_WIDTH-24){1'b0}}, term};
    assign grad_scale = $signed(33'h0_0100_0000) - $signed({3'b000, neg_ln_reg});
    assign biased     = prod_reg + $signed(66'h0_0080_0000);
    assign r_full     = $signed({{11{grad_reg[GRAD_W-1]}}, grad_reg})
                        - $signed({delta_reg[41], delta_reg});
    assign acc_ext    = TOT_EXT_W'(acc_reg);
    assign tot_clip   = (acc_ext > TOT_EXT_W'({TOTAL_W{1'b1}}));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!prob_zero) begin
                        state_next = ST_NORM;
                    end else if (s_tuser == REQ_GRAD) begin
                        state_next = ST_GMUL;
                    end else if (s_tlast) begin
                        state_next = ST_TOUT;
                    end
                end
            end
            ST_NORM:  if (cnt_reg == 5'(NORM_STEPS - 1)) state_next = ST_SQ;
            ST_SQ:    if (cnt_reg == 5'(FRAC_BITS - 1)) state_next = ST_LNMUL;
            ST_LNMUL: state_next = ST_LNRND;
            ST_LNRND: state_next = (req_reg == REQ_GRAD) ? ST_GMUL : ST_TMUL;
            ST_TMUL:  state_next = ST_TACC;
            ST_TACC:  state_next = last_reg ? ST_TOUT : ST_IDLE;
            ST_TOUT:  if (out_free) state_next = ST_IDLE;
            ST_GMUL:  state_next = ST_GRND;
            ST_GRND:  state_next = ST_GOUT;
            ST_GOUT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        req_next      = req_reg;
        last_next     = last_reg;
        p_next        = p_reg;
        norm_next     = norm_reg;
        grad_next     = grad_reg;
        cnt_next      = cnt_reg;
        lz_next       = lz_reg;
        x_next        = x_reg;
        frac_next     = frac_reg;
        neg_ln_next   = neg_ln_reg;
        delta_next    = delta_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        upstream_next = cfg_valid ? cfg_data : upstream_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        okind_next    = okind_reg;
        ototal_next   = ototal_reg;
        ograd_next    = ograd_reg;
        osat_next     = osat_reg;
        mul_a         = '0;
        mul_b         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next  = s_tuser;
                    last_next = s_tlast;
                    p_next    = prob_clamp[31:0];
                    norm_next = prob_clamp;
                    grad_next = s_tdata[PROB_W+GRAD_W-1:PROB_W];
                    cnt_next  = '0;
                    lz_next   = '0;
                    frac_next = '0;
                    if (prob_zero) begin
                        neg_ln_next = NEG_LN_ZERO;
                    end
                end
            end
            ST_NORM: begin
                norm_next = p_step;
                if (top_zero) begin
                    lz_next = lz_reg + shamt;
                end
                if (cnt_reg == 5'(NORM_STEPS - 1)) begin
                    cnt_next = '0;
                    x_next   = p_step[PROB_W-1:2];
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SQ: begin
                mul_a     = {2'b00, x_reg};
                mul_b     = {2'b00, x_reg};
                x_next    = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                frac_next = {frac_reg[FRAC_BITS-2:0], sq_t[31]};
                cnt_next  = (cnt_reg == 5'(FRAC_BITS - 1)) ? 5'd0 : cnt_reg + 5'd1;
            end
            ST_LNMUL: begin
                mul_a = {3'b000, nlog2};
                mul_b = {1'b0, LN2_Q32};
            end
            ST_LNRND: begin
                neg_ln_next = rnd_sum[61:32];
            end
            ST_TMUL: begin
                mul_a = {1'b0, p_reg};
                mul_b = {3'b000, neg_ln_reg};
            end
            ST_TACC: begin
                if (acc_add[ACC_WIDTH]) begin
                    acc_next = '1;
                    ovf_next = 1'b1;
                end else begin
                    acc_next = acc_add[ACC_WIDTH-1:0];
                end
            end
            ST_TOUT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    okind_next  = KIND_ENTROPY;
                    ototal_next = tot_clip ? {TOTAL_W{1'b1}} : acc_ext[TOTAL_W-1:0];
                    ograd_next  = '0;
                    osat_next   = ovf_reg || tot_clip;
                    acc_next    = '0;
                    ovf_next    = 1'b0;
                end
            end
            ST_GMUL: begin
                mul_a = $signed({upstream_reg[31], upstream_reg});
                mul_b = grad_scale;
            end
            ST_GRND: begin
                delta_next = biased[65:24];
            end
            ST_GOUT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    okind_next  = KIND_GRAD;
                    ototal_next = '0;
                    if ((r_full[42:31] == '0) || (r_full[42:31] == '1)) begin
                        ograd_next = r_full[31:0];
                        osat_next  = 1'b0;
                    end else begin
                        ograd_next = r_full[42] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        osat_next  = 1'b1;
                    end
                end
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            upstream_reg <= UPSTREAM_RST;
            mvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            upstream_reg <= upstream_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        last_reg   <= last_next;
        p_reg      <= p_next;
        norm_reg   <= norm_next;
        grad_reg   <= grad_next;
        lz_reg     <= lz_next;
        x_reg      <= x_next;
        frac_reg   <= frac_next;
        neg_ln_reg <= neg_ln_next;
        delta_reg  <= delta_next;
        prod_reg   <= mul_p;
        okind_reg  <= okind_next;
        ototal_reg <= ototal_next;
        ograd_reg  <= ograd_next;
        osat_reg   <= osat_next;
    end

endmodule

>>> src/esg_checker.sv
// port-level checker for the entropy sum and gradient block, bound to the top level
// depends on esg_pkg and assert_macros.svh
`include "assert_macros.svh"

module esg_checker
    import esg_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // a taken gradient item always keeps the block busy, so no input is taken right behind it
    `ESG_ASSERT_NXT(a_grad_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == REQ_GRAD), !s_tready, "input taken during gradient work")

    `ESG_ASSERT_IMP(a_grad_no_total, aclk, aresetn, m_tvalid && (m_tuser == KIND_GRAD), m_tdata[TOTAL_W-1:0] == '0, "gradient item carries a total")

    `ESG_ASSERT_IMP(a_total_no_grad, aclk, aresetn, m_tvalid && (m_tuser == KIND_ENTROPY), m_tdata[TOTAL_W+GRAD_W-1:TOTAL_W] == '0, "entropy item carries a gradient")

    `ESG_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output item changed")

endmodule

bind entropy_sum_and_gradient_top esg_checker u_esg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/tb_top.sv
// testbench for entropy_sum_and_gradient_top: directed table, then random phases under several
// upstream gradient settings, results checked against table or local fixed-point predictor
// depends on esg_pkg and the block itself
module tb_top;
    import esg_pkg::*;

    localparam int          IDLE_LIMIT     = 4000;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          ITEMS_PER_SET  = 230;
    localparam int          N_SETTINGS     = 8;
    localparam int          N_DIRECTED     = 24;
    localparam logic [63:0] ONE_Q32        = 64'h1_0000_0000;
    localparam logic [63:0] ACC_MAX        = (64'd1 << ACC_WIDTH_DEF) - 64'd1;
    localparam logic [63:0] TOTAL_MAX      = (64'd1 << TOTAL_W) - 64'd1;
    localparam logic signed [63:0] LN_ZERO_Q24 = -(64'sd115 <<< 23);

    typedef struct packed {
        logic              kind;
        logic [TOTAL_W-1:0] total;
        logic [GRAD_W-1:0]  grad;
        logic              sat;
    } esg_result_t;

    typedef struct packed {
        logic              req;
        logic [PROB_W-1:0] prob;
        logic [GRAD_W-1:0] grad_in;
        logic              last;
        logic              has_exp;
        esg_result_t       exp_res;
    } stim_row_t;

    localparam esg_result_t NO_RES = '0;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [31:0]          cfg_data = '0;

    // predictor state
    logic [63:0]        acc_sum = '0;
    logic               acc_clipped = 1'b0;
    logic signed [31:0] upstream_q16 = 32'sh0001_0000;

    esg_result_t pending_results[$];
    esg_result_t got_res, want_res;
    int          errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          rx_cycle = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{REQ_ACC,  33'h0_0000_0000, 32'h0000_0000, 1'b1, 1'b1,
          '{KIND_ENTROPY, 48'h0, 32'h0, 1'b0}},
        '{REQ_ACC,  33'h1_0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1,
          '{KIND_ENTROPY, 48'h0, 32'h0, 1'b0}},
        '{REQ_ACC,  33'h1_FFFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
          '{KIND_ENTROPY, 48'h0, 32'h0, 1'b0}},
        '{REQ_ACC,  33'h0_0000_0001, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_FFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_5E2D_58D9, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_0000_0000, 32'h0000_0000, 1'b1, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_8000_0000, 32'h0000_0000, 1'b1, 1'b0, NO_RES},
        '{REQ_GRAD, 33'h1_0000_0000, 32'h0000_0000, 1'b0, 1'b1,
          '{KIND_GRAD, 48'h0, 32'hFFFF_0000, 1'b0}},
        '{REQ_GRAD, 33'h0_0000_0000, 32'h0000_0000, 1'b0, 1'b1,
          '{KIND_GRAD, 48'h0, 32'h0038_8000, 1'b0}},
        '{REQ_GRAD, 33'h0_0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1,
          '{KIND_GRAD, 48'h0, 32'h7FFF_FFFF, 1'b1}},
        '{REQ_GRAD, 33'h1_0000_0000, 32'h8000_0000, 1'b0, 1'b1,
          '{KIND_GRAD, 48'h0, 32'h8000_0000, 1'b1}},
        '{REQ_GRAD, 33'h1_FFFF_FFFF, 32'h1234_5678, 1'b1, 1'b1,
          '{KIND_GRAD, 48'h0, 32'h1233_5678, 1'b0}},
        '{REQ_GRAD, 33'h0_0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
        '{REQ_GRAD, 33'h0_FFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, NO_RES},
        '{REQ_GRAD, 33'h1_5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_AAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_5555_5555, 32'h0000_0000, 1'b1, 1'b0, NO_RES},
        '{REQ_GRAD, 33'h0_0000_0003, 32'h0001_0000, 1'b0, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_4000_0000, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
        '{REQ_GRAD, 33'h0_4000_0000, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_4000_0000, 32'h0000_0000, 1'b1, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_0000_0000, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
        '{REQ_ACC,  33'h0_0000_0000, 32'h0000_0000, 1'b1, 1'b1,
          '{KIND_ENTROPY, 48'h0, 32'h0, 1'b0}}
    };

    entropy_sum_and_gradient_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // -ln(p) in Q.24 for nonzero p in Q1.32, by repeated squaring of the mantissa
    function automatic logic [63:0] nat_log_mag(input logic [PROB_W-1:0] p);
        int unsigned msb;
        logic [63:0] x, frac, nlog2;
        msb = 0;
        for (int i = 0; i < PROB_W; i++)
            if (p[i])
                msb = i;
        x = (msb >= 30) ? (64'(p) >> (msb - 30)) : (64'(p) << (30 - msb));
        frac = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= 64'h8000_0000) begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        nlog2 = (64'(32 - msb) << FRAC_BITS) - frac;
        return (nlog2 * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
    endfunction

    function automatic bit entropy_grad_predict(input stim_row_t it, output esg_result_t res);
        logic [63:0]        p, term;
        logic signed [63:0] lnv, up64, g64, prod, delta, r;
        res = '0;
        p = 64'(it.prob);
        if (p > ONE_Q32)
            p = ONE_Q32;
        if (it.req == REQ_ACC) begin
            if (p != 0) begin
                term = (p * nat_log_mag(p[PROB_W-1:0]) + 64'h8000_0000) >> 32;
                if (term > ACC_MAX - acc_sum) begin
                    acc_sum = ACC_MAX;
                    acc_clipped = 1'b1;
                end else begin
                    acc_sum = acc_sum + term;
                end
            end
            if (!it.last)
                return 1'b0;
            res.kind = KIND_ENTROPY;
            res.sat = acc_clipped;
            if (acc_sum > TOTAL_MAX) begin
                res.total = TOTAL_MAX[TOTAL_W-1:0];
                res.sat = 1'b1;
            end else begin
                res.total = acc_sum[TOTAL_W-1:0];
            end
            acc_sum = '0;
            acc_clipped = 1'b0;
            return 1'b1;
        end
        lnv = (p == 0) ? LN_ZERO_Q24 : -$signed(nat_log_mag(p[PROB_W-1:0]));
        up64 = upstream_q16;
        g64 = $signed(it.grad_in);
        prod = up64 * (lnv + 64'sd16777216);
        delta = (prod + 64'sd8388608) >>> 24;
        r = g64 - delta;
        res.kind = KIND_GRAD;
        if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            res.sat = 1'b1;
        end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.grad = r[31:0];
        return 1'b1;
    endfunction

    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ONE_Q32[PROB_W-1:0];
            2: return {1'b1, 32'($urandom())};
            3: return 33'($urandom_range(1, 255));
            4: return 33'(64'h1_0000_0000 - 64'($urandom_range(1, 1000)));
            5: return {1'b0, 32'($urandom())};
            default: return 33'($urandom() >> $urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [GRAD_W-1:0] rand_grad();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 131071)) - 32'h0001_0000;
            default: return 32'($urandom());
        endcase
    endfunction

    // item is held until the block takes it; valid stays high into the next item unless a gap follows
    task automatic drive_item(input stim_row_t it);
        esg_result_t res;
        int gap;
        gap = 0;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, it.grad_in, it.prob};
        s_tuser  <= it.req;
        s_tlast  <= it.last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (entropy_grad_predict(it, res))
            pending_results.push_back(it.has_exp ? it.exp_res : res);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 9) >= 3)
                gap = $urandom_range(1, 40);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_upstream(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        upstream_q16 = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_items(input int n);
        stim_row_t it;
        int sent, len, pick;
        sent = 0;
        while (sent < n) begin
            it = '0;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // accumulate run closed by last
                len = $urandom_range(1, 16);
                for (int j = 0; j < len; j++) begin
                    it.req = REQ_ACC;
                    it.prob = rand_prob();
                    it.grad_in = 32'($urandom());
                    it.last = (j == len - 1);
                    drive_item(it);
                    sent++;
                end
            end else if (pick < 92) begin
                it.req = REQ_GRAD;
                it.prob = rand_prob();
                it.grad_in = rand_grad();
                drive_item(it);
                sent++;
            end else begin
                // noise: raw fields, stray last flags, unterminated runs
                it.req = 1'($urandom_range(0, 1));
                it.prob = {1'($urandom_range(0, 1)), 32'($urandom())};
                it.grad_in = 32'($urandom());
                it.last = 1'($urandom_range(0, 1));
                drive_item(it);
                sent++;
            end
        end
    endtask

    // receiver stalls, the mode is picked anew at random whenever its run expires
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rx_cycle % 5) < 2;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{m_tuser, m_tdata[47:0], m_tdata[79:48], m_tdata[80]};
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none pending: expected none, actual %h", $time, got_res);
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.kind != want_res.kind) begin
                    errors++;
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, want_res.kind, got_res.kind);
                end
                if (got_res.total != want_res.total) begin
                    errors++;
                    $display("%0t: entropy_total expected %h actual %h",
                             $time, want_res.total, got_res.total);
                end
                if (got_res.grad != want_res.grad) begin
                    errors++;
                    $display("%0t: grad_out expected %h actual %h",
                             $time, want_res.grad, got_res.grad);
                end
                if (got_res.sat != want_res.sat) begin
                    errors++;
                    $display("%0t: saturated expected %0d actual %0d",
                             $time, want_res.sat, got_res.sat);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [31:0] upstream_plan [N_SETTINGS];
        upstream_plan[0] = 32'h8000_0000;
        upstream_plan[1] = 32'h7FFF_FFFF;
        upstream_plan[2] = 32'h0000_0000;
        upstream_plan[3] = 32'hFFFF_FFFF;
        upstream_plan[4] = $urandom();
        upstream_plan[5] = 32'($urandom_range(0, 262143)) - 32'h0002_0000;
        upstream_plan[6] = UPSTREAM_RST;
        upstream_plan[7] = $urandom();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table runs on the reset value of upstream_gradient
        for (int i = 0; i < N_DIRECTED; i++)
            drive_item(directed_rows[i]);
        drain_and_settle();

        for (int k = 0; k < N_SETTINGS; k++) begin
            write_upstream(upstream_plan[k]);
            random_items(ITEMS_PER_SET);
            drain_and_settle();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
